>>> hw/rtl/btr_pkg.sv
`timescale 1ns / 1ps

package btr_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int COORD_BITS_DEF  = 12;

    localparam int REGION_BITS    = 13;
    localparam int INDEX_BITS     = 25;
    localparam int COLOUR_BITS    = 32;
    localparam int ROW_DATA_BITS  = 8;
    localparam int CODE_BITS      = 8;
    localparam int CMD_BITS       = 2;
    localparam int ADDR_IN_BITS   = 12;
    localparam int START_BITS     = 12;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CALC_BITS      = 16;

    localparam logic [REGION_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REGION_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam int LINE_PITCH = 16;
    localparam int CELL_W     = 8;
    localparam int TAB_BASE   = 8 * 3;
    localparam int TAB_STOP   = 4;

    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CHAR  = 2'd2;

    localparam logic [CODE_BITS-1:0] CODE_END   = 8'd0;
    localparam logic [CODE_BITS-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_BITS-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_BITS-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_BITS-1:0] CODE_SPACE = 8'd32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic accept;
        logic read;
        logic advance;
    } ctrl_t;

    typedef struct packed {
        logic draw_char;
        logic pending;
        logic rows_left;
        logic out_free;
        logic last_pending;
    } stat_t;

endpackage

>>> hw/rtl/btr_in_if.sv
`timescale 1ns / 1ps

interface btr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [btr_pkg::CMD_BITS-1:0]         cmd;
    logic [btr_pkg::ADDR_IN_BITS-1:0]     glyph_address;
    logic [btr_pkg::ROW_DATA_BITS-1:0]    glyph_row_bits;
    logic [btr_pkg::CODE_BITS-1:0]        char_code;
    logic [btr_pkg::START_BITS-1:0]       start_x;
    logic [btr_pkg::START_BITS-1:0]       start_y;
    logic [btr_pkg::COLOUR_BITS-1:0]      colour;

    modport source (
        output valid, cmd, glyph_address, glyph_row_bits, char_code, start_x, start_y, colour,
        input  ready
    );
    modport sink (
        input  valid, cmd, glyph_address, glyph_row_bits, char_code, start_x, start_y, colour,
        output ready
    );
endinterface

>>> hw/rtl/btr_out_if.sv
`timescale 1ns / 1ps

interface btr_out_if;
    logic                               valid;
    logic                               ready;
    logic [btr_pkg::INDEX_BITS-1:0]     pixel_index;
    logic [btr_pkg::ROW_DATA_BITS-1:0]  pixel_mask;
    logic [btr_pkg::COLOUR_BITS-1:0]    pixel_value;
    logic                               last_row;

    modport source (
        output valid, pixel_index, pixel_mask, pixel_value, last_row,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, pixel_mask, pixel_value, last_row,
        output ready
    );
endinterface

>>> hw/rtl/btr_ram.sv
`timescale 1ns / 1ps

module btr_ram #(
    parameter int WIDTH = btr_pkg::ROW_DATA_BITS,
    parameter int DEPTH = btr_pkg::GLYPH_COUNT_DEF * btr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/btr_ctrl.sv
`timescale 1ns / 1ps

module btr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  btr_pkg::stat_t  stat,
    output btr_pkg::ctrl_t  ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready     = 1'b0;
        ctrl.accept  = 1'b0;
        ctrl.read    = 1'b0;
        ctrl.advance = 1'b0;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
                if (in_valid && stat.draw_char)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                ctrl.advance = stat.pending && stat.out_free;
                ctrl.read    = stat.rows_left && (!stat.pending || stat.out_free);
                if (ctrl.advance && stat.last_pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/btr_datapath.sv
`timescale 1ns / 1ps

module btr_datapath #(
    parameter int GLYPH_COUNT = btr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = btr_pkg::GLYPH_ROWS_DEF,
    parameter int COORD_BITS  = btr_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  btr_pkg::ctrl_t                       ctrl,
    output btr_pkg::stat_t                       stat,
    input  logic [btr_pkg::CMD_BITS-1:0]         cmd,
    input  logic [btr_pkg::ADDR_IN_BITS-1:0]     glyph_address,
    input  logic [btr_pkg::ROW_DATA_BITS-1:0]    glyph_row_bits,
    input  logic [btr_pkg::CODE_BITS-1:0]        char_code,
    input  logic [btr_pkg::START_BITS-1:0]       start_x,
    input  logic [btr_pkg::START_BITS-1:0]       start_y,
    input  logic [btr_pkg::COLOUR_BITS-1:0]      colour,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [btr_pkg::INDEX_BITS-1:0]       pixel_index,
    output logic [btr_pkg::ROW_DATA_BITS-1:0]    pixel_mask,
    output logic [btr_pkg::COLOUR_BITS-1:0]      pixel_value,
    output logic                                 last_row,
    input  logic                                 cfg_we,
    input  logic [btr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [btr_pkg::REGION_BITS-1:0]      cfg_data
);

    localparam int MEM_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_BITS = $clog2(MEM_DEPTH);
    localparam int ROW_BITS  = $clog2(GLYPH_ROWS);
    localparam int RD_BITS   = $clog2(GLYPH_ROWS + 1);
    localparam int CUR_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = CUR_BITS + btr_pkg::REGION_BITS + 1;
    localparam int CB        = btr_pkg::CALC_BITS;

    logic [CUR_BITS-1:0]                  cursor_x_reg, cursor_x_next;
    logic [CUR_BITS-1:0]                  cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0]                origin_x_reg, origin_x_next;
    logic [btr_pkg::COLOUR_BITS-1:0]      pen_reg, pen_next;
    logic                                 stopped_reg, stopped_next;
    logic [btr_pkg::REGION_BITS-1:0]      width_reg, width_next;
    logic [btr_pkg::REGION_BITS-1:0]      height_reg, height_next;
    logic                                 pending_reg, pending_next;
    logic [RD_BITS-1:0]                   rd_row_reg, rd_row_next;
    logic                                 out_valid_reg, out_valid_next;

    logic [btr_pkg::CODE_BITS-1:0]        code_reg, code_next;
    logic [btr_pkg::INDEX_BITS-1:0]       idx_reg, idx_next;
    logic [ROW_BITS-1:0]                  pend_row_reg, pend_row_next;
    logic [btr_pkg::INDEX_BITS-1:0]       out_index_reg, out_index_next;
    logic [btr_pkg::ROW_DATA_BITS-1:0]    out_mask_reg, out_mask_next;
    logic [btr_pkg::COLOUR_BITS-1:0]      out_value_reg, out_value_next;
    logic                                 out_last_reg, out_last_next;

    logic                                 char_live;
    logic                                 is_move;
    logic                                 draws;
    logic                                 load_ok;
    logic [CB-1:0]                        x_calc;
    logic [CB-1:0]                        y_calc;
    logic [CB-1:0]                        org_calc;
    logic [PROD_BITS-1:0]                 base_full;
    logic [ADDR_BITS-1:0]                 rd_addr;
    logic [btr_pkg::ROW_DATA_BITS-1:0]    rd_data;

    btr_ram #(
        .WIDTH (btr_pkg::ROW_DATA_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_glyph_ram (
        .clk     (clk),
        .wr_en   (ctrl.accept && (cmd == btr_pkg::CMD_LOAD) && load_ok),
        .wr_addr (ADDR_BITS'(glyph_address)),
        .wr_data (glyph_row_bits),
        .rd_en   (ctrl.read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign load_ok = {1'b0, glyph_address} < (btr_pkg::ADDR_IN_BITS + 1)'(MEM_DEPTH);
    assign rd_addr = ADDR_BITS'(ADDR_BITS'(code_reg) * ADDR_BITS'(GLYPH_ROWS)
                                + ADDR_BITS'(rd_row_reg));
    assign base_full = PROD_BITS'(cursor_y_reg) * PROD_BITS'(width_reg)
                       + PROD_BITS'(cursor_x_reg);

    always_comb
    begin
        char_live = (cmd == btr_pkg::CMD_CHAR) && !stopped_reg;
        is_move   = (char_code == btr_pkg::CODE_TAB) || (char_code == btr_pkg::CODE_LF)
                    || (char_code == btr_pkg::CODE_CR) || (char_code == btr_pkg::CODE_SPACE);
        draws     = char_live && (char_code != btr_pkg::CODE_END) && !is_move
                    && ({1'b0, char_code} < (btr_pkg::CODE_BITS + 1)'(GLYPH_COUNT));

        org_calc = CB'(origin_x_reg);
        x_calc   = CB'(cursor_x_reg);
        y_calc   = CB'(cursor_y_reg);
        unique case (char_code)
            btr_pkg::CODE_LF:
            begin
                y_calc = y_calc + CB'(btr_pkg::LINE_PITCH);
                x_calc = org_calc;
            end
            btr_pkg::CODE_CR:
            begin
                x_calc = org_calc;
            end
            btr_pkg::CODE_TAB:
            begin
                x_calc = x_calc + CB'(btr_pkg::TAB_BASE)
                         + CB'(3'(btr_pkg::TAB_STOP) - {1'b0, cursor_x_reg[1:0]});
            end
            default:
            begin
                x_calc = x_calc + CB'(btr_pkg::CELL_W);
            end
        endcase
        if (x_calc + CB'(btr_pkg::CELL_W) >= CB'(width_reg))
        begin
            x_calc = org_calc;
            y_calc = y_calc + CB'(btr_pkg::LINE_PITCH);
        end
    end

    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        origin_x_next  = origin_x_reg;
        pen_next       = pen_reg;
        stopped_next   = stopped_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        code_next      = code_reg;
        idx_next       = idx_reg;
        rd_row_next    = rd_row_reg;
        pend_row_next  = pend_row_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_mask_next  = out_mask_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                btr_pkg::REG_WIDTH:  width_next  = cfg_data;
                btr_pkg::REG_HEIGHT: height_next = cfg_data;
                default:             width_next  = width_reg;
            endcase
        end

        if (ctrl.accept)
        begin
            if (cmd == btr_pkg::CMD_START)
            begin
                origin_x_next = COORD_BITS'(start_x);
                cursor_x_next = CUR_BITS'(COORD_BITS'(start_x));
                cursor_y_next = CUR_BITS'(COORD_BITS'(start_y));
                pen_next      = colour;
                stopped_next  = 1'b0;
            end
            else if (char_live)
            begin
                if (char_code == btr_pkg::CODE_END)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    cursor_x_next = CUR_BITS'(x_calc);
                    cursor_y_next = CUR_BITS'(y_calc);
                    stopped_next  = y_calc >= CB'(height_reg);
                end
            end
            if (draws)
            begin
                code_next   = char_code;
                idx_next    = btr_pkg::INDEX_BITS'(base_full);
                rd_row_next = '0;
            end
        end

        if (ctrl.read)
        begin
            rd_row_next   = rd_row_reg + RD_BITS'(1);
            pend_row_next = ROW_BITS'(rd_row_reg);
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.advance)
        begin
            out_valid_next = 1'b1;
            out_index_next = idx_reg;
            out_mask_next  = rd_data;
            out_value_next = pen_reg;
            out_last_next  = stat.last_pending;
            idx_next       = idx_reg + btr_pkg::INDEX_BITS'(width_reg);
        end

        if (ctrl.read)
        begin
            pending_next = 1'b1;
        end
        else if (ctrl.advance)
        begin
            pending_next = 1'b0;
        end
    end

    always_comb
    begin
        stat.draw_char    = draws;
        stat.pending      = pending_reg;
        stat.rows_left    = rd_row_reg != RD_BITS'(GLYPH_ROWS);
        stat.out_free     = !out_valid_reg || out_ready;
        stat.last_pending = pend_row_reg == ROW_BITS'(GLYPH_ROWS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            origin_x_reg  <= '0;
            pen_reg       <= '0;
            stopped_reg   <= 1'b1;
            width_reg     <= btr_pkg::WIDTH_RESET;
            height_reg    <= btr_pkg::HEIGHT_RESET;
            pending_reg   <= 1'b0;
            rd_row_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            origin_x_reg  <= origin_x_next;
            pen_reg       <= pen_next;
            stopped_reg   <= stopped_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            pending_reg   <= pending_next;
            rd_row_reg    <= rd_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        idx_reg       <= idx_next;
        pend_row_reg  <= pend_row_next;
        out_index_reg <= out_index_next;
        out_mask_reg  <= out_mask_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = out_index_reg;
    assign pixel_mask  = out_mask_reg;
    assign pixel_value = out_value_reg;
    assign last_row    = out_last_reg;

endmodule

>>> hw/rtl/bitmap_text_renderer.sv
`timescale 1ns / 1ps

// Text renderer that draws 8-pixel-wide glyphs from an internal glyph memory.
// The text channel carries one word per item: a glyph row load, a start word
// that sets origin, cursor and colour, or a character word. The pixels channel
// returns one word per glyph row with the framebuffer index of the row's
// leftmost pixel, an 8-bit write mask (bit 7 leftmost), the colour and a flag
// on the final row. Region width and height are written on the cfg port; the user
// must do so only while the block is idle, which the block itself does not enforce.
// Load, start, control and non-printing character words are taken in the idle state.
// A printable glyph drops ready on the text channel while its rows are read one per
// cycle, when the receiver keeps up, through the single read port of the glyph
// memory; each row word passes through the memory's read register and then the
// output stage before it appears on the pixels channel.
// A registered output stage holds each row word while the receiver stalls; the
// row reads pause with it, and the next item may be accepted while the final
// row still waits. Reset stops rendering until a start word, sets the region to
// 640 by 480 and leaves the glyph memory contents undefined until loaded.
module bitmap_text_renderer #(
    parameter int GLYPH_COUNT = btr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = btr_pkg::GLYPH_ROWS_DEF,
    parameter int COORD_BITS  = btr_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    btr_in_if.sink                              text,
    btr_out_if.source                           pixels,
    input  logic                                cfg_we,
    input  logic [btr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [btr_pkg::REGION_BITS-1:0]     cfg_data
);

    btr_pkg::ctrl_t ctrl;
    btr_pkg::stat_t stat;

    btr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (text.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    btr_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cmd            (text.cmd),
        .glyph_address  (text.glyph_address),
        .glyph_row_bits (text.glyph_row_bits),
        .char_code      (text.char_code),
        .start_x        (text.start_x),
        .start_y        (text.start_y),
        .colour         (text.colour),
        .out_valid      (pixels.valid),
        .out_ready      (pixels.ready),
        .pixel_index    (pixels.pixel_index),
        .pixel_mask     (pixels.pixel_mask),
        .pixel_value    (pixels.pixel_value),
        .last_row       (pixels.last_row),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // No glyph row read may be in flight or started while new words are taken.
    a_idle_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
        text.ready |-> (!stat.pending && !ctrl.read))
        else $error("glyph row read active while text channel is ready");

    // Moving the final row into the output stage returns the block to idle.
    a_last_row_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.advance && stat.last_pending) |=> text.ready)
        else $error("text channel not ready after final glyph row");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

localparam logic [btr_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
localparam int GLYPH_MEM_DEPTH = btr_pkg::GLYPH_COUNT_DEF * btr_pkg::GLYPH_ROWS_DEF;

typedef struct packed {
    logic [btr_pkg::CMD_BITS-1:0]      cmd;
    logic [btr_pkg::ADDR_IN_BITS-1:0]  glyph_address;
    logic [btr_pkg::ROW_DATA_BITS-1:0] glyph_row_bits;
    logic [btr_pkg::CODE_BITS-1:0]     char_code;
    logic [btr_pkg::START_BITS-1:0]    start_x;
    logic [btr_pkg::START_BITS-1:0]    start_y;
    logic [btr_pkg::COLOUR_BITS-1:0]   colour;
} text_word_t;

typedef struct packed {
    logic [btr_pkg::INDEX_BITS-1:0]    pixel_index;
    logic [btr_pkg::ROW_DATA_BITS-1:0] pixel_mask;
    logic [btr_pkg::COLOUR_BITS-1:0]   pixel_value;
    logic                              last_row;
} pixel_word_t;

class render_checker;
    logic [btr_pkg::ROW_DATA_BITS-1:0] glyph_rows [GLYPH_MEM_DEPTH];
    logic [btr_pkg::REGION_BITS-1:0]   pen_x;
    logic [btr_pkg::REGION_BITS-1:0]   pen_y;
    logic [btr_pkg::START_BITS-1:0]    home_x;
    logic [btr_pkg::COLOUR_BITS-1:0]   pen_colour;
    bit                                halted;
    logic [btr_pkg::REGION_BITS-1:0]   width;
    logic [btr_pkg::REGION_BITS-1:0]   height;
    pixel_word_t                       row_writes_due [$];
    int                                errors;

    function new();
        pen_x      = '0;
        pen_y      = '0;
        home_x     = '0;
        pen_colour = '0;
        halted     = 1'b1;
        width      = btr_pkg::WIDTH_RESET;
        height     = btr_pkg::HEIGHT_RESET;
        errors     = 0;
    endfunction

    function void set_region(logic [btr_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [btr_pkg::REGION_BITS-1:0] val);
        if (idx == btr_pkg::REG_WIDTH)
            width = val;
        else
            height = val;
    endfunction

    function int outstanding();
        return row_writes_due.size();
    endfunction

    function void flag(string msg);
        errors++;
        $error("%s", msg);
    endfunction

    function void note_text_word(text_word_t w);
        int unsigned      nx;
        int unsigned      ny;
        int               r;
        longint unsigned  idx;
        pixel_word_t      row;
        unique case (w.cmd)
            btr_pkg::CMD_LOAD:
                glyph_rows[w.glyph_address] = w.glyph_row_bits;
            btr_pkg::CMD_START:
            begin
                home_x     = w.start_x;
                pen_x      = btr_pkg::REGION_BITS'(w.start_x);
                pen_y      = btr_pkg::REGION_BITS'(w.start_y);
                pen_colour = w.colour;
                halted     = 1'b0;
            end
            btr_pkg::CMD_CHAR:
            begin
                if (!halted)
                begin
                    if (w.char_code == btr_pkg::CODE_END)
                        halted = 1'b1;
                    else
                    begin
                        nx = 32'(pen_x);
                        ny = 32'(pen_y);
                        unique case (w.char_code)
                            btr_pkg::CODE_LF:
                            begin
                                ny += btr_pkg::LINE_PITCH;
                                nx = 32'(home_x);
                            end
                            btr_pkg::CODE_CR:
                                nx = 32'(home_x);
                            btr_pkg::CODE_TAB:
                                nx += btr_pkg::TAB_BASE
                                      + (btr_pkg::TAB_STOP - nx % btr_pkg::TAB_STOP);
                            btr_pkg::CODE_SPACE:
                                nx += btr_pkg::CELL_W;
                            default:
                            begin
                                for (r = 0; r < btr_pkg::GLYPH_ROWS_DEF; r++)
                                begin
                                    idx = (longint'(pen_y) + longint'(r)) * longint'(width)
                                          + longint'(pen_x);
                                    row.pixel_index = idx[btr_pkg::INDEX_BITS-1:0];
                                    row.pixel_mask  =
                                        glyph_rows[w.char_code * btr_pkg::GLYPH_ROWS_DEF + r];
                                    row.pixel_value = pen_colour;
                                    row.last_row    = (r == btr_pkg::GLYPH_ROWS_DEF - 1);
                                    row_writes_due.push_back(row);
                                end
                                nx += btr_pkg::CELL_W;
                            end
                        endcase
                        if (nx + btr_pkg::CELL_W >= width)
                        begin
                            nx = 32'(home_x);
                            ny += btr_pkg::LINE_PITCH;
                        end
                        if (ny >= height)
                            halted = 1'b1;
                        pen_x = nx[btr_pkg::REGION_BITS-1:0];
                        pen_y = ny[btr_pkg::REGION_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void check_row_write(pixel_word_t got);
        pixel_word_t want;
        if (row_writes_due.size() == 0)
        begin
            flag($sformatf("unexpected row write, pixel_index %0h", got.pixel_index));
            return;
        end
        want = row_writes_due.pop_front();
        if (got.pixel_index !== want.pixel_index)
            flag($sformatf("pixel_index: expected %0h, got %0h",
                want.pixel_index, got.pixel_index));
        if (got.pixel_mask !== want.pixel_mask)
            flag($sformatf("pixel_mask: expected %0h, got %0h",
                want.pixel_mask, got.pixel_mask));
        if (got.pixel_value !== want.pixel_value)
            flag($sformatf("pixel_value: expected %0h, got %0h",
                want.pixel_value, got.pixel_value));
        if (got.last_row !== want.last_row)
            flag($sformatf("last_row: expected %0b, got %0b", want.last_row, got.last_row));
    endfunction
endclass

module testbench;

    localparam int LIMIT      = 500000;
    localparam int PHASES     = 6;
    localparam int PHASE_SIZE = 55;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [btr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [btr_pkg::REGION_BITS-1:0]    cfg_data;

    btr_in_if  text ();
    btr_out_if pixels ();

    bitmap_text_renderer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .pixels    (pixels),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    render_checker      sb = new();
    int                 hold_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 words_sent = 0;
    int                 cycle_count = 0;
    bit                 row_loaded [GLYPH_MEM_DEPTH];
    bit                 glyph_ready [btr_pkg::GLYPH_COUNT_DEF];
    logic [btr_pkg::CODE_BITS-1:0] ready_codes [$];
    logic [btr_pkg::CODE_BITS-1:0] motion_codes [4] = '{btr_pkg::CODE_TAB, btr_pkg::CODE_LF,
                                                         btr_pkg::CODE_CR, btr_pkg::CODE_SPACE};
    int                 region_w [PHASES] = '{640, 4096, 1, 0, 8191, 0};
    int                 region_h [PHASES] = '{480, 4096, 1, 0, 8191, 0};
    int                 send_pct [PHASES] = '{0, 45, 0, 29, 0, 45};
    int                 recv_pct [PHASES] = '{0, 0, 45, 29, 0, 29};

    always #2 clk = ~clk;

    function automatic text_word_t random_word(logic [btr_pkg::CMD_BITS-1:0] cmd);
        text_word_t w;
        w.cmd            = cmd;
        w.glyph_address  = btr_pkg::ADDR_IN_BITS'($urandom_range(4095, 0));
        w.glyph_row_bits = btr_pkg::ROW_DATA_BITS'($urandom_range(255, 0));
        w.char_code      = btr_pkg::CODE_BITS'($urandom_range(255, 0));
        w.start_x        = btr_pkg::START_BITS'($urandom_range(4095, 0));
        w.start_y        = btr_pkg::START_BITS'($urandom_range(4095, 0));
        w.colour         = $urandom;
        return w;
    endfunction

    function automatic text_word_t load_word(int addr,
                                             logic [btr_pkg::ROW_DATA_BITS-1:0] bits);
        text_word_t w;
        w = random_word(btr_pkg::CMD_LOAD);
        w.glyph_address  = btr_pkg::ADDR_IN_BITS'(addr);
        w.glyph_row_bits = bits;
        return w;
    endfunction

    function automatic text_word_t start_word(int x, int y,
                                              logic [btr_pkg::COLOUR_BITS-1:0] c);
        text_word_t w;
        w = random_word(btr_pkg::CMD_START);
        w.start_x = btr_pkg::START_BITS'(x);
        w.start_y = btr_pkg::START_BITS'(y);
        w.colour  = c;
        return w;
    endfunction

    function automatic text_word_t char_word(logic [btr_pkg::CODE_BITS-1:0] code);
        text_word_t w;
        w = random_word(btr_pkg::CMD_CHAR);
        w.char_code = code;
        return w;
    endfunction

    task automatic send_word(input text_word_t w);
        int  code;
        int  r;
        bit  full;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            text.valid <= 1'b0;
            @(posedge clk);
        end
        text.valid          <= 1'b1;
        text.cmd            <= w.cmd;
        text.glyph_address  <= w.glyph_address;
        text.glyph_row_bits <= w.glyph_row_bits;
        text.char_code      <= w.char_code;
        text.start_x        <= w.start_x;
        text.start_y        <= w.start_y;
        text.colour         <= w.colour;
        @(posedge clk);
        while (!text.ready)
            @(posedge clk);
        sb.note_text_word(w);
        words_sent++;
        if (w.cmd == btr_pkg::CMD_LOAD)
        begin
            row_loaded[w.glyph_address] = 1'b1;
            code = w.glyph_address / btr_pkg::GLYPH_ROWS_DEF;
            if (code != btr_pkg::CODE_END && !glyph_ready[code])
            begin
                full = 1'b1;
                for (r = 0; r < btr_pkg::GLYPH_ROWS_DEF; r++)
                    if (!row_loaded[code * btr_pkg::GLYPH_ROWS_DEF + r])
                        full = 1'b0;
                if (full)
                begin
                    glyph_ready[code] = 1'b1;
                    ready_codes.push_back(btr_pkg::CODE_BITS'(code));
                end
            end
        end
    endtask

    task automatic drain();
        text.valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_region(logic [btr_pkg::REGION_BITS-1:0] w,
                                logic [btr_pkg::REGION_BITS-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= btr_pkg::REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= btr_pkg::REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_region(btr_pkg::REG_WIDTH, w);
        sb.set_region(btr_pkg::REG_HEIGHT, h);
    endtask

    task automatic send_random();
        int          roll;
        int          code;
        int          r;
        int          span;
        text_word_t  w;
        roll = $urandom_range(99, 0);
        if (roll < 4)
        begin
            code = $urandom_range(255, 1);
            for (r = 0; r < btr_pkg::GLYPH_ROWS_DEF; r++)
                send_word(load_word(code * btr_pkg::GLYPH_ROWS_DEF + r,
                    btr_pkg::ROW_DATA_BITS'($urandom_range(255, 0))));
        end
        else if (roll < 11)
            send_word(random_word(btr_pkg::CMD_LOAD));
        else if (roll < 22)
        begin
            w = random_word(btr_pkg::CMD_START);
            span = (sb.width == 0 || sb.width > 4096) ? 4096 : sb.width;
            if ($urandom_range(3, 0) != 0)
                w.start_x = btr_pkg::START_BITS'($urandom_range(span - 1, 0));
            span = (sb.height == 0 || sb.height > 4096) ? 4096 : sb.height;
            if ($urandom_range(3, 0) != 0)
                w.start_y = btr_pkg::START_BITS'($urandom_range(span - 1, 0));
            send_word(w);
        end
        else if (roll < 24)
            send_word(random_word(CMD_UNUSED));
        else
        begin
            roll = $urandom_range(99, 0);
            if (roll < 25)
                send_word(char_word(motion_codes[$urandom_range(3, 0)]));
            else if (roll < 30)
                send_word(char_word(btr_pkg::CODE_END));
            else
                send_word(char_word(ready_codes[$urandom_range(ready_codes.size() - 1, 0)]));
        end
    endtask

    initial
    begin
        pixel_word_t got;
        pixels.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixels.valid && pixels.ready)
            begin
                got.pixel_index = pixels.pixel_index;
                got.pixel_mask  = pixels.pixel_mask;
                got.pixel_value = pixels.pixel_value;
                got.last_row    = pixels.last_row;
                sb.check_row_write(got);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pixels.ready <= 1'b0;
            end
            else
                pixels.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int p;
        int r;
        int goal;
        bit paused;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = btr_pkg::REG_WIDTH;
        cfg_data            = '0;
        text.valid          = 1'b0;
        text.cmd            = btr_pkg::CMD_LOAD;
        text.glyph_address  = '0;
        text.glyph_row_bits = '0;
        text.char_code      = '0;
        text.start_x        = '0;
        text.start_y        = '0;
        text.colour         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset region of 640 by 480 stays in force through the directed words.
        for (r = 0; r < btr_pkg::GLYPH_ROWS_DEF; r++)
            send_word(load_word(255 * btr_pkg::GLYPH_ROWS_DEF + r,
                (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'h01 << (r % 8)));
        send_word(char_word(8'd255));
        send_word(random_word(CMD_UNUSED));
        send_word(start_word(0, 0, 32'hFFFF_FFFF));
        send_word(char_word(8'd255));
        send_word(char_word(btr_pkg::CODE_TAB));
        send_word(char_word(btr_pkg::CODE_LF));
        send_word(char_word(btr_pkg::CODE_CR));
        send_word(char_word(btr_pkg::CODE_SPACE));
        send_word(start_word(4095, 0, 32'h0000_0000));
        send_word(char_word(8'd255));
        send_word(char_word(btr_pkg::CODE_END));
        send_word(char_word(8'd255));
        send_word(start_word(600, 4095, 32'hA5A5_5A5A));
        send_word(char_word(8'd255));
        send_word(char_word(8'd255));
        send_word(load_word(0, 8'hFF));

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == PHASES - 1)
                write_region(btr_pkg::REGION_BITS'($urandom_range(700, 16)),
                             btr_pkg::REGION_BITS'($urandom_range(600, 32)));
            else
                write_region(btr_pkg::REGION_BITS'(region_w[p]),
                             btr_pkg::REGION_BITS'(region_h[p]));
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            if (p == 4)
                hold_cycles = 300;
            paused = 1'b0;
            goal = words_sent + PHASE_SIZE;
            while (words_sent < goal)
            begin
                if (p == 1 && !paused && words_sent >= goal - PHASE_SIZE / 2)
                begin
                    paused = 1'b1;
                    drain();
                end
                send_random();
            end
        end
        drain();

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
